// ===== sv/vector2d_geometry_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef VECTOR2D_GEOMETRY_UNIT_MACROS_SVH
`define VECTOR2D_GEOMETRY_UNIT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define V2G_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define V2G_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/v2g_pkg.sv =====
// types, codes and arithmetic helpers of the 2d vector unit
`default_nettype none
package v2g_pkg;

	// operation codes
	typedef enum logic [3:0] {
		OP_ADD        = 4'd0,
		OP_SUB        = 4'd1,
		OP_NEG        = 4'd2,
		OP_DOT        = 4'd3,
		OP_CROSS      = 4'd4,
		OP_LENGTH     = 4'd5,
		OP_NORMALIZE  = 4'd6,
		OP_ROTATE     = 4'd7,
		OP_USCALE     = 4'd8,
		OP_CSCALE     = 4'd9,
		OP_MIRROR     = 4'd10,
		OP_TRANSFORM  = 4'd11,
		OP_UTRANSFORM = 4'd12,
		OP_LEFTORTHO  = 4'd13
	} op_t;

	// intermediates clamp at +-2^62
	localparam logic signed [63:0] CLAMP_LIM = 64'sh4000_0000_0000_0000;
	localparam logic signed [64:0] CLAMP_LIM65 = 65'sh0_4000_0000_0000_0000;

	// classified item leaving the front part
	typedef struct packed {
		op_t                op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic [31:0]        ux;
		logic [31:0]        uy;
		logic               sx;
		logic               sy;
		logic               zl;
		logic               norm;
	} cls_t;

	// partial products of one multiply lane
	typedef struct packed {
		logic [63:0] lo;
		logic [62:0] hi;
		logic        neg;
	} part_t;

	// item as it travels the back pipeline
	typedef struct packed {
		cls_t               c;
		logic [63:0]        n;
		logic [63:0]        r;
		logic [63:0]        remx;
		logic [63:0]        remy;
		logic [63:0]        dv;
		logic [31:0]        qx;
		logic [31:0]        qy;
		logic signed [63:0] nx;
		logic signed [63:0] ny;
		part_t              pp0;
		part_t              pp1;
		part_t              pp2;
		part_t              pp3;
		logic signed [63:0] p0;
		logic signed [63:0] p1;
		logic signed [63:0] p2;
		logic signed [63:0] p3;
		logic signed [63:0] t;
		logic signed [63:0] u;
		logic signed [63:0] q0;
		logic signed [63:0] q1;
		logic signed [63:0] rx;
		logic signed [63:0] ry;
	} item_t;

	// 32 by 32 unsigned product
	function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
		logic [63:0] p;
		p = x * y;
		return p;
	endfunction

	// magnitude of a signed word
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// sum clamped to +-2^62, operands within that range
	function automatic logic signed [63:0] addc(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > CLAMP_LIM65) begin
			return CLAMP_LIM;
		end else if (s < -CLAMP_LIM65) begin
			return -CLAMP_LIM;
		end
		return $signed(s[63:0]);
	endfunction

	// split product: a below 2^63 in magnitude, b at most 2^31
	function automatic part_t part_prod(input logic signed [63:0] a,
			input logic signed [32:0] b);
		part_t o;
		logic [63:0] ua;
		logic [32:0] ub;
		logic [63:0] h;
		ua = mag64(a);
		ub = b[32] ? 33'(-b) : 33'(b);
		o.lo = mul32(ua[31:0], ub[31:0]);
		h = mul32(ua[63:32], ub[31:0]);
		o.hi = h[62:0];
		o.neg = a[63] ^ b[32];
		return o;
	endfunction

	// join partials, round half away from zero, clamp, apply sign
	function automatic logic signed [63:0] fmul_comb(input part_t p,
			input int unsigned frac);
		logic [95:0] full;
		logic [95:0] shf;
		logic [62:0] r;
		full = {1'b0, p.hi, 32'd0} + {32'd0, p.lo} + (96'd1 << (frac - 1));
		shf = full >> frac;
		if (shf > {32'd0, CLAMP_LIM}) begin
			r = CLAMP_LIM[62:0];
		end else begin
			r = shf[62:0];
		end
		return p.neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

endpackage
`default_nettype wire

// ===== sv/v2g_front.sv =====
// front part: takes items and classifies the vector to normalize or measure
`default_nettype none
module v2g_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [255:0]   s_tdata,
	input  wire logic [3:0]     s_tuser,
	output logic                cls_valid,
	input  wire logic           cls_ready,
	output v2g_pkg::cls_t       cls_data
);

	v2g_pkg::cls_t     cls_d;
	v2g_pkg::cls_t     cls_s1;
	logic              vld_s1;
	logic signed [32:0] vx;
	logic signed [32:0] vy;
	logic [32:0]       mx;
	logic [32:0]       my;

	// unpack and pick the vector for the length path
	always_comb begin
		cls_d = '0;
		cls_d.op = v2g_pkg::op_t'(s_tuser);
		cls_d.ax = s_tdata[31:0];
		cls_d.ay = s_tdata[63:32];
		cls_d.bx = s_tdata[95:64];
		cls_d.by = s_tdata[127:96];
		cls_d.cx = s_tdata[159:128];
		cls_d.cy = s_tdata[191:160];
		cls_d.dx = s_tdata[223:192];
		cls_d.dy = s_tdata[255:224];
		case (cls_d.op)
			v2g_pkg::OP_LEFTORTHO: begin
				vx = -33'(cls_d.ay);
				vy = 33'(cls_d.ax);
			end
			v2g_pkg::OP_MIRROR: begin
				vx = 33'(cls_d.bx);
				vy = 33'(cls_d.by);
			end
			default: begin
				vx = 33'(cls_d.ax);
				vy = 33'(cls_d.ay);
			end
		endcase
		mx = vx[32] ? 33'(-vx) : 33'(vx);
		my = vy[32] ? 33'(-vy) : 33'(vy);
		cls_d.ux = mx[31:0];
		cls_d.uy = my[31:0];
		cls_d.sx = vx[32];
		cls_d.sy = vy[32];
		cls_d.norm = (cls_d.op != v2g_pkg::OP_LENGTH);
		cls_d.zl = (mx == 33'd0) && (my == 33'd0) &&
			((cls_d.op == v2g_pkg::OP_NORMALIZE) || (cls_d.op == v2g_pkg::OP_MIRROR) ||
			(cls_d.op == v2g_pkg::OP_LEFTORTHO));
	end

	assign s_tready = !vld_s1 || cls_ready;

	// valid of the classify register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload of the classify register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cls_s1 <= cls_d;
		end
	end

	assign cls_valid = vld_s1;
	assign cls_data = cls_s1;

endmodule
`default_nettype wire

// ===== sv/v2g_queue.sv =====
// short queue between the front and back parts
`default_nettype none
module v2g_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire v2g_pkg::cls_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output v2g_pkg::cls_t       out_data
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PW = $clog2(DEPTH);

	v2g_pkg::cls_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;
	logic           push;
	logic           pop;

	assign in_ready = (cnt_q != (PW + 1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule
`default_nettype wire

// ===== sv/v2g_back.sv =====
// back part: length, normalize and multiply pipeline with the output register
`default_nettype none
module v2g_back #(
	parameter int unsigned FRACTION_BITS = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire v2g_pkg::cls_t  in_data,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [63:0]         m_tdata,
	output logic [1:0]          m_tuser
);

	// stage map
	localparam int unsigned QB = FRACTION_BITS + 2;
	localparam int unsigned SQ = 6;
	localparam int unsigned SUM = 7;
	localparam int unsigned RT0 = 8;
	localparam int unsigned RND = RT0 + 32;
	localparam int unsigned DIN = RND + 1;
	localparam int unsigned DV0 = DIN + 1;
	localparam int unsigned SGN = DV0 + QB;
	localparam int unsigned M1A = SGN + 1;
	localparam int unsigned M1B = SGN + 2;
	localparam int unsigned AD1 = SGN + 3;
	localparam int unsigned M2A = SGN + 4;
	localparam int unsigned M2B = SGN + 5;
	localparam int unsigned FIN = SGN + 6;
	localparam int unsigned NST = FIN + 1;

	localparam int unsigned SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRACTION_BITS;

	v2g_pkg::item_t pipe_q [NST];
	logic [NST-1:0] vld_q;
	v2g_pkg::item_t entry;
	logic           adv;
	logic           ov_x;
	logic           ov_y;
	logic [31:0]    sat_x;
	logic [31:0]    sat_y;

	assign adv = !m_tvalid || m_tready;
	assign in_ready = adv;

	// item entering the pipeline
	always_comb begin
		entry = '0;
		entry.c = in_data;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// entry register
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_q[0] <= entry;
		end
	end

	for (genvar i = 1; i < NST; i++) begin : g_stage
		v2g_pkg::item_t cur;
		v2g_pkg::item_t nxt;
		assign cur = pipe_q[i-1];

		if (i < SQ) begin : g_shift
			// normalizing shift, one binary step per stage
			localparam int unsigned SH = 16 >> (i - 1);
			logic [31:0] m;
			always_comb begin
				nxt = cur;
				m = (cur.c.ux > cur.c.uy) ? cur.c.ux : cur.c.uy;
				if (cur.c.norm && (m < (32'd1 << (31 - SH)))) begin
					nxt.c.ux = cur.c.ux << SH;
					nxt.c.uy = cur.c.uy << SH;
				end
			end
		end else if (i == SQ) begin : g_square
			// squares of the components
			always_comb begin
				nxt = cur;
				nxt.remx = v2g_pkg::mul32(cur.c.ux, cur.c.ux);
				nxt.remy = v2g_pkg::mul32(cur.c.uy, cur.c.uy);
			end
		end else if (i == SUM) begin : g_sum
			// sum of squares
			always_comb begin
				nxt = cur;
				nxt.n = cur.remx + cur.remy;
				nxt.r = '0;
			end
		end else if (i < RND) begin : g_sqrt
			// one square root digit per stage
			localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * (i - RT0));
			always_comb begin
				nxt = cur;
				if (cur.n >= cur.r + RBIT) begin
					nxt.n = cur.n - (cur.r + RBIT);
					nxt.r = (cur.r >> 1) + RBIT;
				end else begin
					nxt.r = cur.r >> 1;
				end
			end
		end else if (i == RND) begin : g_round
			// round the root to nearest
			always_comb begin
				nxt = cur;
				if (cur.n > cur.r) begin
					nxt.r = cur.r + 64'd1;
				end
			end
		end else if (i == DIN) begin : g_dinit
			// dividends with half the divisor added for rounding
			always_comb begin
				nxt = cur;
				nxt.remx = ({32'd0, cur.c.ux} << FRACTION_BITS) + (cur.r >> 1);
				nxt.remy = ({32'd0, cur.c.uy} << FRACTION_BITS) + (cur.r >> 1);
				nxt.dv = cur.r;
				nxt.qx = '0;
				nxt.qy = '0;
			end
		end else if (i < SGN) begin : g_div
			// one quotient bit per stage in both lanes
			localparam int unsigned QS = QB - 1 - (i - DV0);
			logic [63:0] dsh;
			always_comb begin
				nxt = cur;
				dsh = cur.dv << QS;
				if (cur.remx >= dsh) begin
					nxt.remx = cur.remx - dsh;
					nxt.qx[QS] = 1'b1;
				end
				if (cur.remy >= dsh) begin
					nxt.remy = cur.remy - dsh;
					nxt.qy[QS] = 1'b1;
				end
			end
		end else if (i == SGN) begin : g_sign
			// signed unit vector, zero vector maps to (1,0)
			always_comb begin
				nxt = cur;
				if (cur.c.zl) begin
					nxt.nx = FX_ONE;
					nxt.ny = '0;
				end else begin
					nxt.nx = cur.c.sx ? -$signed({32'd0, cur.qx}) : $signed({32'd0, cur.qx});
					nxt.ny = cur.c.sy ? -$signed({32'd0, cur.qy}) : $signed({32'd0, cur.qy});
				end
			end
		end else if (i == M1A) begin : g_mul1a
			// first products, partials
			always_comb begin
				nxt = cur;
				case (cur.c.op)
					v2g_pkg::OP_DOT: begin
						nxt.pp0 = v2g_pkg::part_prod(64'(cur.c.ax), 33'(cur.c.bx));
						nxt.pp1 = v2g_pkg::part_prod(64'(cur.c.ay), 33'(cur.c.by));
					end
					v2g_pkg::OP_CROSS: begin
						nxt.pp0 = v2g_pkg::part_prod(64'(cur.c.ax), 33'(cur.c.by));
						nxt.pp1 = v2g_pkg::part_prod(64'(cur.c.bx), 33'(cur.c.ay));
					end
					v2g_pkg::OP_ROTATE, v2g_pkg::OP_TRANSFORM, v2g_pkg::OP_UTRANSFORM: begin
						nxt.pp0 = v2g_pkg::part_prod(64'(cur.c.ax), 33'(cur.c.cx));
						nxt.pp1 = v2g_pkg::part_prod(64'(cur.c.ay), 33'(cur.c.cy));
						nxt.pp2 = v2g_pkg::part_prod(64'(cur.c.ax), 33'(cur.c.cy));
						nxt.pp3 = v2g_pkg::part_prod(64'(cur.c.ay), 33'(cur.c.cx));
					end
					v2g_pkg::OP_USCALE: begin
						nxt.pp0 = v2g_pkg::part_prod(64'(cur.c.ax), 33'(cur.c.dx));
						nxt.pp1 = v2g_pkg::part_prod(64'(cur.c.ay), 33'(cur.c.dx));
					end
					v2g_pkg::OP_CSCALE: begin
						nxt.pp0 = v2g_pkg::part_prod(64'(cur.c.ax), 33'(cur.c.dx));
						nxt.pp1 = v2g_pkg::part_prod(64'(cur.c.ay), 33'(cur.c.dy));
					end
					v2g_pkg::OP_MIRROR: begin
						nxt.pp0 = v2g_pkg::part_prod(cur.nx, 33'(cur.c.ax));
						nxt.pp1 = v2g_pkg::part_prod(cur.ny, 33'(cur.c.ay));
					end
					default: begin
						nxt.pp0 = cur.pp0;
					end
				endcase
			end
		end else if (i == M1B) begin : g_mul1b
			// first products, rounded
			always_comb begin
				nxt = cur;
				nxt.p0 = v2g_pkg::fmul_comb(cur.pp0, FRACTION_BITS);
				nxt.p1 = v2g_pkg::fmul_comb(cur.pp1, FRACTION_BITS);
				nxt.p2 = v2g_pkg::fmul_comb(cur.pp2, FRACTION_BITS);
				nxt.p3 = v2g_pkg::fmul_comb(cur.pp3, FRACTION_BITS);
			end
		end else if (i == AD1) begin : g_add1
			// sums of products
			logic signed [63:0] s;
			always_comb begin
				nxt = cur;
				s = v2g_pkg::addc(cur.p0, cur.p1);
				case (cur.c.op)
					v2g_pkg::OP_DOT: begin
						nxt.t = s;
					end
					v2g_pkg::OP_MIRROR: begin
						nxt.t = v2g_pkg::addc(s, s);
					end
					default: begin
						nxt.t = v2g_pkg::addc(cur.p0, -cur.p1);
						nxt.u = v2g_pkg::addc(cur.p2, cur.p3);
					end
				endcase
			end
		end else if (i == M2A) begin : g_mul2a
			// second products, partials
			always_comb begin
				nxt = cur;
				case (cur.c.op)
					v2g_pkg::OP_MIRROR: begin
						nxt.pp0 = v2g_pkg::part_prod(cur.t, $signed(cur.nx[32:0]));
						nxt.pp1 = v2g_pkg::part_prod(cur.t, $signed(cur.ny[32:0]));
					end
					v2g_pkg::OP_TRANSFORM: begin
						nxt.pp0 = v2g_pkg::part_prod(cur.t, 33'(cur.c.dx));
						nxt.pp1 = v2g_pkg::part_prod(cur.u, 33'(cur.c.dy));
					end
					v2g_pkg::OP_UTRANSFORM: begin
						nxt.pp0 = v2g_pkg::part_prod(cur.t, 33'(cur.c.dx));
						nxt.pp1 = v2g_pkg::part_prod(cur.u, 33'(cur.c.dx));
					end
					default: begin
						nxt.pp0 = cur.pp0;
					end
				endcase
			end
		end else if (i == M2B) begin : g_mul2b
			// second products, rounded
			always_comb begin
				nxt = cur;
				nxt.q0 = v2g_pkg::fmul_comb(cur.pp0, FRACTION_BITS);
				nxt.q1 = v2g_pkg::fmul_comb(cur.pp1, FRACTION_BITS);
			end
		end else begin : g_final
			// result selection before saturation
			always_comb begin
				nxt = cur;
				nxt.rx = '0;
				nxt.ry = '0;
				case (cur.c.op)
					v2g_pkg::OP_ADD: begin
						nxt.rx = 64'(cur.c.ax) + 64'(cur.c.bx);
						nxt.ry = 64'(cur.c.ay) + 64'(cur.c.by);
					end
					v2g_pkg::OP_SUB: begin
						nxt.rx = 64'(cur.c.ax) - 64'(cur.c.bx);
						nxt.ry = 64'(cur.c.ay) - 64'(cur.c.by);
					end
					v2g_pkg::OP_NEG: begin
						nxt.rx = -64'(cur.c.ax);
						nxt.ry = -64'(cur.c.ay);
					end
					v2g_pkg::OP_DOT, v2g_pkg::OP_CROSS: begin
						nxt.rx = cur.t;
					end
					v2g_pkg::OP_LENGTH: begin
						nxt.rx = $signed(cur.r);
					end
					v2g_pkg::OP_NORMALIZE, v2g_pkg::OP_LEFTORTHO: begin
						nxt.rx = cur.nx;
						nxt.ry = cur.ny;
					end
					v2g_pkg::OP_ROTATE: begin
						nxt.rx = cur.t;
						nxt.ry = cur.u;
					end
					v2g_pkg::OP_USCALE, v2g_pkg::OP_CSCALE: begin
						nxt.rx = cur.p0;
						nxt.ry = cur.p1;
					end
					v2g_pkg::OP_MIRROR: begin
						nxt.rx = v2g_pkg::addc(64'(cur.c.ax), -cur.q0);
						nxt.ry = v2g_pkg::addc(64'(cur.c.ay), -cur.q1);
					end
					v2g_pkg::OP_TRANSFORM, v2g_pkg::OP_UTRANSFORM: begin
						nxt.rx = v2g_pkg::addc(cur.q0, 64'(cur.c.bx));
						nxt.ry = v2g_pkg::addc(cur.q1, 64'(cur.c.by));
					end
					default: begin
						nxt.rx = '0;
					end
				endcase
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_q[i] <= nxt;
			end
		end
	end

	// saturation of both components
	always_comb begin
		ov_x = 1'b0;
		ov_y = 1'b0;
		sat_x = pipe_q[NST-1].rx[31:0];
		sat_y = pipe_q[NST-1].ry[31:0];
		if (pipe_q[NST-1].rx > SAT_HI) begin
			sat_x = SAT_HI[31:0];
			ov_x = 1'b1;
		end else if (pipe_q[NST-1].rx < SAT_LO) begin
			sat_x = SAT_LO[31:0];
			ov_x = 1'b1;
		end
		if (pipe_q[NST-1].ry > SAT_HI) begin
			sat_y = SAT_HI[31:0];
			ov_y = 1'b1;
		end else if (pipe_q[NST-1].ry < SAT_LO) begin
			sat_y = SAT_LO[31:0];
			ov_y = 1'b1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= vld_q[NST-1];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {sat_y, sat_x};
			m_tuser <= {ov_x || ov_y, pipe_q[NST-1].c.zl};
		end
	end

endmodule
`default_nettype wire

// ===== sv/vector2d_geometry_unit.sv =====
// top level of the 2d fixed point vector unit
//
// Takes one item per cycle while s_tready is high and gives one result item
// per item, in order. From the edge that loads the classify register, an item
// passes one queue write, a pipeline of FRACTION_BITS + 51 stages and the
// output register; the pipeline depth is set by the 32-stage square root and
// the FRACTION_BITS + 2 stage divider of the normalize path, which every item
// goes through so that results stay in order. A four-item queue between the
// classify register and the pipeline lets the input keep taking items while
// the output is stalled until the queue fills. All operands and results are
// two's complement with FRACTION_BITS fraction bits; results saturate to
// min(WORD_BITS, 32) bits and flag it in overflow.
`default_nettype none
module vector2d_geometry_unit #(
	parameter int unsigned FRACTION_BITS = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
	input  wire logic [255:0] s_tdata,
	// operation
	input  wire logic [3:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_x, result_y
	output logic [63:0]       m_tdata,
	// zero_length, overflow
	output logic [1:0]        m_tuser
);

	logic          cls_valid;
	logic          cls_ready;
	v2g_pkg::cls_t cls_data;
	logic          q_valid;
	logic          q_ready;
	v2g_pkg::cls_t q_data;

	v2g_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls_data  (cls_data)
	);

	v2g_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_valid),
		.in_ready  (cls_ready),
		.in_data   (cls_data),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	v2g_back #(
		.FRACTION_BITS (FRACTION_BITS),
		.WORD_BITS     (WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_data  (q_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== sv/v2g_checker.sv =====
// port checker of the 2d vector unit and its bind
`default_nettype none
`include "vector2d_geometry_unit_macros.svh"
module v2g_checker #(
	parameter int unsigned WORD_BITS = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	localparam int unsigned SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic [31:0] SAT_HI = 32'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic [31:0] SAT_LO = ~SAT_HI;

	// a stalled result item holds
	`V2G_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

	// overflow only with a component at a saturation limit
	`V2G_ASSERT(a_ovf_limit, clk, arst_n, m_tvalid && m_tuser[1] |-> (m_tdata[31:0] == SAT_HI) || (m_tdata[31:0] == SAT_LO) || (m_tdata[63:32] == SAT_HI) || (m_tdata[63:32] == SAT_LO), "overflow without a saturated component")

	// nothing offered while in reset
	`V2G_ASSERT_NORST(a_rst_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind vector2d_geometry_unit v2g_checker #(.WORD_BITS(WORD_BITS)) u_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the 2d fixed point vector unit
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	typedef struct {
		v2g_pkg::op_t op;
		logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
	} vec_item_t;

	typedef struct {
		logic [31:0] rx, ry;
		logic zl, ov;
	} vec_result_t;

	localparam int FRAC = 16;
	localparam longint LIM = 64'sh4000_0000_0000_0000;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [255:0] s_tdata;
	logic [3:0] s_tuser;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;

	vec_item_t pending_items[$];
	vec_result_t expected_results[$];
	int error_count;
	int send_idle_pct, recv_stall_pct;
	bit recv_hold;
	bit stim_done;
	bit in_taken;

	vector2d_geometry_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// exact 64x64 fixed-point product of wide operands, rounded half away, clamped
	function automatic longint fx_mul(input longint a, input longint b);
		logic [63:0] ua, ub, r;
		logic [127:0] p;
		ua = a < 0 ? 64'(-a) : 64'(a);
		ub = b < 0 ? 64'(-b) : 64'(b);
		p = {64'd0, ua} * {64'd0, ub};
		p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
		r = (p > 128'(LIM)) ? 64'(LIM) : p[63:0];
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sum_clamp(input longint a, input longint b);
		if (a > 0 && b > LIM - a) return LIM;
		if (a < 0 && b < -LIM - a) return -LIM;
		return a + b;
	endfunction

	// square root rounded to nearest
	function automatic logic [63:0] sqrt_round(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (n > r) r = r + 1;
		return r;
	endfunction

	// unit vector of (x, y); returns 1 for the zero vector, which maps to (1, 0)
	function automatic bit unit_vec(input longint x, input longint y,
			output longint ox, output longint oy);
		logic [63:0] ux, uy, m, len;
		ux = x < 0 ? 64'(-x) : 64'(x);
		uy = y < 0 ? 64'(-y) : 64'(y);
		if (ux == 0 && uy == 0) begin
			ox = 64'sd1 << FRAC;
			oy = 0;
			return 1'b1;
		end
		m = ux > uy ? ux : uy;
		while (m < (64'd1 << 30)) begin
			m = m << 1;
			ux = ux << 1;
			uy = uy << 1;
		end
		len = sqrt_round(ux * ux + uy * uy);
		ux = ((ux << FRAC) + (len >> 1)) / len;
		uy = ((uy << FRAC) + (len >> 1)) / len;
		ox = x < 0 ? -longint'(ux) : longint'(ux);
		oy = y < 0 ? -longint'(uy) : longint'(uy);
		return 1'b0;
	endfunction

	function automatic logic [31:0] sat32(input longint v, inout bit ov);
		if (v > 64'sd2147483647) begin
			ov = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			ov = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic vec_result_t vector_op(input vec_item_t it);
		vec_result_t res;
		longint ax, ay, bx, by, cx, cy, dx, dy, rx, ry, nx, ny, t, u;
		logic [63:0] mx, my;
		bit zl, ov;
		ax = it.ax; ay = it.ay; bx = it.bx; by = it.by;
		cx = it.cx; cy = it.cy; dx = it.dx; dy = it.dy;
		rx = 0; ry = 0; zl = 0; ov = 0;
		case (it.op)
			v2g_pkg::OP_ADD: begin rx = ax + bx; ry = ay + by; end
			v2g_pkg::OP_SUB: begin rx = ax - bx; ry = ay - by; end
			v2g_pkg::OP_NEG: begin rx = -ax; ry = -ay; end
			v2g_pkg::OP_DOT: rx = sum_clamp(fx_mul(ax, bx), fx_mul(ay, by));
			v2g_pkg::OP_CROSS: rx = sum_clamp(fx_mul(ax, by), -fx_mul(bx, ay));
			v2g_pkg::OP_LENGTH: begin
				mx = ax < 0 ? 64'(-ax) : 64'(ax);
				my = ay < 0 ? 64'(-ay) : 64'(ay);
				rx = longint'(sqrt_round(mx * mx + my * my));
			end
			v2g_pkg::OP_NORMALIZE: zl = unit_vec(ax, ay, rx, ry);
			v2g_pkg::OP_ROTATE: begin
				rx = sum_clamp(fx_mul(ax, cx), -fx_mul(ay, cy));
				ry = sum_clamp(fx_mul(ax, cy), fx_mul(ay, cx));
			end
			v2g_pkg::OP_USCALE: begin rx = fx_mul(ax, dx); ry = fx_mul(ay, dx); end
			v2g_pkg::OP_CSCALE: begin rx = fx_mul(ax, dx); ry = fx_mul(ay, dy); end
			v2g_pkg::OP_MIRROR: begin
				zl = unit_vec(bx, by, nx, ny);
				t = sum_clamp(fx_mul(ax, nx), fx_mul(ay, ny));
				t = sum_clamp(t, t);
				rx = sum_clamp(ax, -fx_mul(nx, t));
				ry = sum_clamp(ay, -fx_mul(ny, t));
			end
			v2g_pkg::OP_TRANSFORM, v2g_pkg::OP_UTRANSFORM: begin
				t = sum_clamp(fx_mul(ax, cx), -fx_mul(ay, cy));
				u = sum_clamp(fx_mul(ax, cy), fx_mul(ay, cx));
				rx = sum_clamp(fx_mul(t, dx), bx);
				ry = sum_clamp(fx_mul(u, it.op == v2g_pkg::OP_TRANSFORM ? dy : dx), by);
			end
			v2g_pkg::OP_LEFTORTHO: zl = unit_vec(-ay, ax, rx, ry);
			default: ;
		endcase
		res.rx = sat32(rx, ov);
		res.ry = sat32(ry, ov);
		res.zl = zl;
		res.ov = ov;
		return res;
	endfunction

	// operand value biased toward edge cases and small magnitudes
	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
			4, 5: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
			6: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_item_t rand_item();
		vec_item_t it;
		it.op = v2g_pkg::op_t'($urandom_range(0, 15));
		it.ax = rand_operand(); it.ay = rand_operand();
		it.bx = rand_operand(); it.by = rand_operand();
		it.cx = rand_operand(); it.cy = rand_operand();
		it.dx = rand_operand(); it.dy = rand_operand();
		// a proper unit rotation for about half of the rotating items
		if ($urandom_range(0, 1)) begin
			it.cx = 32'sh0000_b505;
			it.cy = $urandom_range(0, 1) ? 32'sh0000_b505 : -32'sh0000_b505;
		end
		return it;
	endfunction

	function automatic vec_item_t mk(input v2g_pkg::op_t op, input logic [31:0] ax, ay, bx,
			by, cx, cy, dx, dy);
		vec_item_t it;
		it.op = op;
		it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
		it.cx = cx; it.cy = cy; it.dx = dx; it.dy = dy;
		return it;
	endfunction

	// driver: offers items from the pending queue at the falling edge
	always @(negedge clk or negedge arst_n) begin
		vec_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || in_taken) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.op;
				s_tdata <= {it.dy, it.dx, it.cy, it.cx, it.by, it.bx, it.ay, it.ax};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// input accept at the rising edge: expected result and driver release
	always @(posedge clk) begin
		vec_item_t it;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken) begin
			it.op = v2g_pkg::op_t'(s_tuser);
			{it.dy, it.dx, it.cy, it.cx, it.by, it.bx, it.ay, it.ax} = s_tdata;
			expected_results.push_back(vector_op(it));
		end
	end

	// receiver ready, changed at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor: compares each accepted result with the oldest expectation
	always @(posedge clk) begin
		vec_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected: %h %h", m_tdata, m_tuser);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (m_tdata[31:0] !== exp_r.rx) begin
					$error("result_x expected %h actual %h", exp_r.rx, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[63:32] !== exp_r.ry) begin
					$error("result_y expected %h actual %h", exp_r.ry, m_tdata[63:32]);
					error_count++;
				end
				if (m_tuser[0] !== exp_r.zl) begin
					$error("zero_length expected %b actual %b", exp_r.zl, m_tuser[0]);
					error_count++;
				end
				if (m_tuser[1] !== exp_r.ov) begin
					$error("overflow expected %b actual %b", exp_r.ov, m_tuser[1]);
					error_count++;
				end
			end
		end
	end

	// long receiver hold-off, counted in its own process
	initial begin
		recv_hold = 1'b0;
		wait (stim_done == 1'b0 && pending_items.size() > 700);
		wait (pending_items.size() < 600);
		recv_hold = 1'b1;
		repeat (300) @(negedge clk);
		recv_hold = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("testbench: errors");
		$finish;
	end

	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
	endtask

	task automatic add_random(input int count);
		repeat (count) pending_items.push_back(rand_item());
	endtask

	initial begin
		error_count = 0;
		stim_done = 1'b1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every operation, field extremes, zero vectors, unused codes
		pending_items.push_back(mk(v2g_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff,
			32'h0000_0001, 32'hffff_ffff, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_NEG, 32'h8000_0000, 32'h7fff_ffff,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_DOT, 32'h0002_0000, 32'h0003_0000,
			32'h0004_0000, 32'hffff_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_DOT, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_CROSS, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_LENGTH, 32'h8000_0000, 32'h8000_0000,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_LENGTH, 32'h0003_0000, 32'h0004_0000,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_NORMALIZE, 32'h8000_0000, 32'h0000_0001,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_NORMALIZE, 32'h0000_0001, 32'hffff_ffff,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_ROTATE, 32'h0001_0000, 32'h0002_0000, 32'h0,
			32'h0, 32'h0000_b505, 32'h0000_b505, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_USCALE, 32'h7fff_ffff, 32'h8000_0000,
			0, 0, 0, 0, 32'h0002_0000, 0));
		pending_items.push_back(mk(v2g_pkg::OP_CSCALE, 32'h0001_8000, 32'hfffe_8000,
			0, 0, 0, 0, 32'h0000_8000, 32'hffff_8000));
		pending_items.push_back(mk(v2g_pkg::OP_MIRROR, 32'h0003_0000, 32'h0005_0000,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_MIRROR, 32'h0003_0000, 32'h0005_0000,
			32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_MIRROR, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_TRANSFORM, 32'h0001_0000, 32'h0002_0000,
			32'h0010_0000, 32'hfff0_0000, 32'h0001_0000, 0, 32'h0002_0000, 32'h0003_0000));
		pending_items.push_back(mk(v2g_pkg::OP_UTRANSFORM, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0));
		pending_items.push_back(mk(v2g_pkg::OP_LEFTORTHO, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::OP_LEFTORTHO, 32'h0001_0000, 32'h8000_0000,
			0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(v2g_pkg::op_t'(4'd14), 32'h1234_5678, 1, 2, 3, 4, 5, 6, 7));
		pending_items.push_back(mk(v2g_pkg::op_t'(4'd15), 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff));
		drain();

		// random phases with different idling on both sides
		add_random(250);
		drain();
		send_idle_pct = 50;
		add_random(250);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 50;
		add_random(250);
		drain();
		send_idle_pct = 23;
		recv_stall_pct = 23;
		stim_done = 1'b0;
		add_random(760);
		drain();
		stim_done = 1'b1;

		// a short final burst, then an idle stretch with nothing outstanding
		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_random(20);
		drain();
		repeat (100) @(posedge clk);

		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/v2g_pkg.sv
sv/v2g_front.sv
sv/v2g_queue.sv
sv/v2g_back.sv
sv/vector2d_geometry_unit.sv
sv/v2g_checker.sv
tb/sv/testbench.sv
